/* rtl/gcrs_pkg.sv */
// package for the grid cell and region store
// holds shared constants, codes, word structs and controller/datapath signal groups
// no dependencies
`timescale 1ns / 1ps

package gcrs_pkg;

    // default sizes of the grid and the region label
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int MAX_HEIGHT_DEF  = 64;
    localparam int REGION_BITS_DEF = 12;

    // fixed field widths
    localparam int CMD_W   = 3;
    localparam int COORD_W = 6;
    localparam int CELL_W  = 2;
    localparam int LABEL_W = 12;
    localparam int DIM_W   = 7;
    localparam int SUM_W   = 14;   // holds 63 * 127 + 63
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // cell kinds
    localparam logic [CELL_W-1:0] CELL_WALL      = 2'd0;
    localparam logic [CELL_W-1:0] CELL_ATTENTION = 2'd2;
    localparam logic [CELL_W-1:0] CELL_BAD       = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_RD_CELL    = 3'd0,
        CMD_WR_CELL    = 3'd1,
        CMD_RD_REGION  = 3'd2,
        CMD_WR_REGION  = 3'd3,
        CMD_NEW_REGION = 3'd4,
        CMD_JOIN       = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_EXEC,
        ST_JOIN_B,
        ST_JOIN_CMP,
        ST_SWEEP,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        RD_A,
        RD_B,
        RD_SWEEP
    } rd_sel_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
        logic [CELL_W-1:0]  cell_in;
        logic [LABEL_W-1:0] region_in;
    } in_word_t;

    typedef struct packed {
        logic [CELL_W-1:0]  cell_out;
        logic [LABEL_W-1:0] region_out;
        logic               error;
    } out_word_t;

    // controller to datapath
    typedef struct packed {
        logic    clear_en;
        logic    capture;
        logic    calc;
        rd_sel_t rd_sel;
        logic    wr_cell;
        logic    wr_region;
        logic    latch_ra;
        logic    sweep_init;
        logic    sweep_run;
        logic    finish;
        logic    issue;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             ok_a;
        logic             ok_ab;
        logic             labels_eq;
        logic             clr_last;
        logic             sweep_done;
    } sts_t;

endpackage

/* rtl/gcrs_ctrl.sv */
// controller state machine of the grid cell and region store
// sequences clear pass, command steps and join sweep; depends on gcrs_pkg
`timescale 1ns / 1ps

module gcrs_ctrl
    import gcrs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        ctl.rd_sel = RD_A;
        busy       = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                ctl.clear_en = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.capture = 1'b1;
                    state_next  = ST_CALC;
                end
            end
            ST_CALC:
            begin
                ctl.calc   = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // reads of point a are issued here for every command
                state_next = ST_RESP;
                case (cmd_t'(sts.cmd))
                    CMD_WR_CELL:   ctl.wr_cell   = sts.ok_a;
                    CMD_WR_REGION: ctl.wr_region = sts.ok_a;
                    CMD_JOIN:
                    begin
                        if (sts.ok_ab)
                        begin
                            state_next = ST_JOIN_B;
                        end
                    end
                    default: ;
                endcase
            end
            ST_JOIN_B:
            begin
                ctl.rd_sel   = RD_B;
                ctl.latch_ra = 1'b1;
                state_next   = ST_JOIN_CMP;
            end
            ST_JOIN_CMP:
            begin
                if (sts.labels_eq)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    ctl.sweep_init = 1'b1;
                    state_next     = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                ctl.sweep_run = 1'b1;
                ctl.rd_sel    = RD_SWEEP;
                if (sts.sweep_done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                ctl.finish = 1'b1;
                ctl.issue  = (sts.cmd == CMD_NEW_REGION);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/gcrs_dp.sv */
// datapath of the grid cell and region store
// cell and region memories, address math, join sweep, label counter; depends on gcrs_pkg
`timescale 1ns / 1ps

module gcrs_dp
    import gcrs_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int REGION_BITS = REGION_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctl_t             ctl,
    input  in_word_t         req,
    input  logic [DIM_W-1:0] grid_width,
    input  logic [DIM_W-1:0] grid_height,
    output sts_t             sts,
    output out_word_t        rsp,
    output logic             done
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;
    localparam int SW    = (CW > SUM_W) ? CW : SUM_W;
    localparam int RW    = REGION_BITS;

    logic [CELL_W-1:0] cell_mem   [DEPTH];
    logic [RW-1:0]     region_mem [DEPTH];

    // captured command word
    logic [CMD_W-1:0]   cmd_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [COORD_W-1:0] x2_reg;
    logic [COORD_W-1:0] y2_reg;
    logic [CELL_W-1:0]  cell_in_reg;
    logic [LABEL_W-1:0] region_in_reg;

    logic [AW-1:0] addr_a_reg;
    logic [AW-1:0] addr_b_reg;
    logic          ok_a_reg;
    logic          ok_ab_reg;
    logic [CW-1:0] n_reg;

    logic [CELL_W-1:0] cell_rd_reg;
    logic [RW-1:0]     region_rd_reg;
    logic [RW-1:0]     ra_reg;
    logic [RW-1:0]     rb_reg;
    logic [RW-1:0]     next_region_reg;

    logic [AW-1:0] clr_idx_reg;
    logic [CW-1:0] idx_reg;
    logic [AW-1:0] pidx_reg;
    logic          pend_reg;

    out_word_t rsp_reg;
    logic      done_reg;

    logic [DIM_W-1:0]  eff_w;
    logic [DIM_W-1:0]  eff_h;
    logic [SW-1:0]     sum_a;
    logic [SW-1:0]     sum_b;
    logic [SW-1:0]     area;
    logic              in_a;
    logic              in_b;
    logic              sweep_more;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              cell_we;
    logic              region_we;
    logic [CELL_W-1:0] cell_wd;
    logic [RW-1:0]     region_wd;
    logic [CELL_W-1:0] cell_sat;
    out_word_t         rsp_next;

    // effective grid size and address math
    always_comb
    begin
        eff_w = (32'(grid_width) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : grid_width;
        eff_h = (32'(grid_height) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : grid_height;
        in_a  = (DIM_W'(x_reg) < eff_w) && (DIM_W'(y_reg) < eff_h);
        in_b  = (DIM_W'(x2_reg) < eff_w) && (DIM_W'(y2_reg) < eff_h);
        sum_a = SW'(y_reg) * SW'(eff_w) + SW'(x_reg);
        sum_b = SW'(y2_reg) * SW'(eff_w) + SW'(x2_reg);
        area  = SW'(eff_w) * SW'(eff_h);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg       <= req.cmd;
            x_reg         <= req.x;
            y_reg         <= req.y;
            x2_reg        <= req.x2;
            y2_reg        <= req.y2;
            cell_in_reg   <= req.cell_in;
            region_in_reg <= req.region_in;
        end
        if (ctl.calc)
        begin
            addr_a_reg <= sum_a[AW-1:0];
            addr_b_reg <= sum_b[AW-1:0];
            ok_a_reg   <= in_a;
            ok_ab_reg  <= in_a && in_b;
            n_reg      <= area[CW-1:0];
        end
        if (ctl.latch_ra)
        begin
            ra_reg <= region_rd_reg;
        end
        if (ctl.sweep_init)
        begin
            rb_reg <= region_rd_reg;
        end
        if (ctl.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // memory port selection
    assign sweep_more = (idx_reg < n_reg);
    assign cell_sat   = (cell_in_reg == CELL_BAD) ? CELL_ATTENTION : cell_in_reg;

    always_comb
    begin
        case (ctl.rd_sel)
            RD_B:     rd_addr = addr_b_reg;
            RD_SWEEP: rd_addr = idx_reg[AW-1:0];
            default:  rd_addr = addr_a_reg;
        endcase

        if (ctl.clear_en)
        begin
            wr_addr = clr_idx_reg;
        end
        else if (ctl.sweep_run)
        begin
            wr_addr = pidx_reg;
        end
        else
        begin
            wr_addr = addr_a_reg;
        end

        cell_we   = ctl.clear_en || ctl.wr_cell;
        cell_wd   = ctl.clear_en ? CELL_WALL : cell_sat;
        region_we = ctl.clear_en || ctl.wr_region ||
                    (ctl.sweep_run && pend_reg && (region_rd_reg == ra_reg));
        if (ctl.clear_en)
        begin
            region_wd = '0;
        end
        else if (ctl.sweep_run)
        begin
            region_wd = rb_reg;
        end
        else
        begin
            region_wd = RW'(region_in_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[wr_addr] <= cell_wd;
        end
        cell_rd_reg <= cell_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (region_we)
        begin
            region_mem[wr_addr] <= region_wd;
        end
        region_rd_reg <= region_mem[rd_addr];
    end

    // clear pass, sweep counters, label counter, result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg     <= '0;
            idx_reg         <= '0;
            pidx_reg        <= '0;
            pend_reg        <= 1'b0;
            next_region_reg <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (ctl.clear_en)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
            end
            if (ctl.sweep_init)
            begin
                idx_reg  <= '0;
                pend_reg <= 1'b0;
            end
            else if (ctl.sweep_run)
            begin
                pend_reg <= sweep_more;
                if (sweep_more)
                begin
                    pidx_reg <= idx_reg[AW-1:0];
                    idx_reg  <= idx_reg + CW'(1);
                end
            end
            if (ctl.issue)
            begin
                next_region_reg <= next_region_reg + RW'(1);
            end
            done_reg <= ctl.finish;
        end
    end

    always_comb
    begin
        rsp_next = '0;
        if (cmd_reg inside {CMD_RD_CELL, CMD_WR_CELL, CMD_RD_REGION, CMD_WR_REGION})
        begin
            rsp_next.error = !ok_a_reg;
        end
        else if (cmd_reg == CMD_JOIN)
        begin
            rsp_next.error = !ok_ab_reg;
        end
        if (cmd_reg == CMD_RD_CELL && ok_a_reg)
        begin
            rsp_next.cell_out = cell_rd_reg;
        end
        if (cmd_reg == CMD_RD_REGION && ok_a_reg)
        begin
            rsp_next.region_out = LABEL_W'(region_rd_reg);
        end
        else if (cmd_reg == CMD_NEW_REGION)
        begin
            rsp_next.region_out = LABEL_W'(next_region_reg);
        end
    end

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.ok_a       = ok_a_reg;
        sts.ok_ab      = ok_ab_reg;
        sts.labels_eq  = (ra_reg == region_rd_reg);
        sts.clr_last   = (clr_idx_reg == AW'(DEPTH - 1));
        sts.sweep_done = (idx_reg == n_reg) && !pend_reg;
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule

/* rtl/grid_cell_and_region_store_top.sv */
// grid cell and region store, top level: apb config registers, controller, datapath
// depends on gcrs_pkg, gcrs_ctrl, gcrs_dp
// sequence: read, write, new region and failed commands pass the idle capture, calc, exec
//   and resp states; a join adds join_b and join_cmp, and with unequal labels a sweep
//   over width*height cells; a new word is taken only when idle, since the controller
//   walks the capture, address, store access and result steps one after the other
// reset: config regs go to 64 x 64, then a clearing pass over all MAX_WIDTH*MAX_HEIGHT cells
`timescale 1ns / 1ps

module grid_cell_and_region_store_top
    import gcrs_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int REGION_BITS = REGION_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // command side
    input  logic              start,
    output logic              busy,
    input  in_word_t          req,
    // result side, no backpressure
    output logic              done,
    output out_word_t         rsp,
    // apb config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [DIM_W-1:0] grid_width_reg;
    logic [DIM_W-1:0] grid_height_reg;
    logic             cfg_wr;

    ctl_t ctl;
    sts_t sts;

    // config registers, written at the access phase; pready tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= DIM_RESET;
            grid_height_reg <= DIM_RESET;
        end
        else if (cfg_wr)
        begin
            // register index is the word address
            if (paddr[2] == REG_GRID_WIDTH)
            begin
                grid_width_reg <= pwdata[DIM_W-1:0];
            end
            else
            begin
                grid_height_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    // read back
    assign prdata = (paddr[2] == REG_GRID_HEIGHT) ? APB_DW'(grid_height_reg)
                                                  : APB_DW'(grid_width_reg);

    // controller: clear pass after reset, then one word at a time
    gcrs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    // datapath: both stores, bounds and address math, join sweep, label counter
    gcrs_dp #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .REGION_BITS (REGION_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .req         (req),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .sts         (sts),
        .rsp         (rsp),
        .done        (done)
    );

    // a result only follows a cycle in which the block was busy
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without preceding busy cycle");

    // accepted word makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a word");

    // results are never back to back
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // a finished sweep leads straight to the result step
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.sweep_run && sts.sweep_done) |=> ctl.finish)
        else $error("sweep end not followed by finish");

    // no store write traffic from commands during the clear pass
    a_clear_excl: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear_en |-> !(ctl.wr_cell || ctl.wr_region || ctl.sweep_run || ctl.capture))
        else $error("command activity during clear pass");

endmodule
